// ----- hdl/hptc_pkg.sv -----
// ----------------------------------------------------------------------------
// hptc_pkg: shared types and constants for the hashed probe threshold cache
// Request and result payloads, cache entry layout, controller command and
// status groups, controller state encoding and fixed field constants.
// ----------------------------------------------------------------------------
package hptc_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_CACHE_ENTRIES = 256;
    localparam int DEF_PROBE_COUNT   = 4;
    localparam int DEF_SLOT_COUNT    = 64;

    // Key mixing
    localparam logic [63:0] HASH_MUL   = 64'hff51_afd7_ed55_8ccd;
    localparam int          HASH_SHIFT = 33;

    // Controller handle decode
    localparam logic [31:0] HANDLE_MASK = 32'h0000_7FFF;
    localparam logic [31:0] HANDLE_ALL  = 32'hFFFF_FFFF;
    localparam int          HLOW_W      = 15;

    // Entry field widths and fill values
    localparam int               USES_W       = 11;
    localparam int               THR_W        = 20;
    localparam logic [USES_W-1:0] USES_VALID   = 11'd1024;
    localparam logic [USES_W-1:0] USES_INVALID = 11'd32;
    localparam logic [THR_W-1:0]  THRESH_MAX   = 20'd1000000;
    localparam logic [31:0]       GEN_RESET    = 32'd1;
    localparam int                COUNT_W      = 7;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [63:0]      bot_key;
        logic [31:0]      controller_handle;
        logic [5:0]       slot_index;
        logic [THR_W-1:0] new_threshold;
        logic             clear_override;
    } req_t;

    typedef struct packed {
        logic             threshold_present;
        logic [THR_W-1:0] threshold_milli;
        logic             cache_hit;
        logic             override_active;
    } res_t;

    typedef struct packed {
        logic [63:0]       key;
        logic [31:0]       gen;
        logic [USES_W-1:0] uses;
        logic              present;
        logic [THR_W-1:0]  thr;
    } cache_entry_t;

    typedef struct packed {
        logic idle;
        logic load;
        logic clear_step;
        logic hash_step;
        logic slot_read;
        logic probe;
        logic entry_write;
        logic slot_write;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic req_is_set;
        logic req_key_zero;
        logic hash_done;
        logic scan_done;
        logic out_free;
    } ctrl_sts_t;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_HASH   = 8'b0000_0100,
        ST_PROBE  = 8'b0000_1000,
        ST_WRITE  = 8'b0001_0000,
        ST_SETRD  = 8'b0010_0000,
        ST_SETWR  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

endpackage

// ----- hdl/hptc_hash.sv -----
// ----------------------------------------------------------------------------
// hptc_hash: multi-cycle key mixer
// Computes the low 64 bits of (k ^ k>>33) * HASH_MUL with one 32x32
// multiplier over four steps; the caller applies the final xor-shift.
// ----------------------------------------------------------------------------
module hptc_hash import hptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr,
    input  logic        step,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);

    logic [1:0]  cnt_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] x;
    logic [31:0] op_a;
    logic [31:0] op_b;

    // First xor-shift of the key
    assign x = key ^ (key >> HASH_SHIFT);

    // Partial product select: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
    assign op_a = (cnt_reg == 2'd2) ? x[63:32] : x[31:0];
    assign op_b = (cnt_reg == 2'd1) ? HASH_MUL[63:32] : HASH_MUL[31:0];

    assign done = step && (cnt_reg == 2'd3);
    assign hash = acc_reg;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (clr)
        begin
            cnt_reg <= 2'd0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    // Product register, then accumulate the shifted cross terms
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            prod_reg <= op_a * op_b;
            case (cnt_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                2'd3:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

// ----- hdl/hptc_ctrl.sv -----
// ----------------------------------------------------------------------------
// hptc_ctrl: sequencing controller; drives the datapath via one command group
// Clears the cache after reset, then walks lookups through hash, probe, write
// and result phases and sets through slot read, slot write and result phases.
// ----------------------------------------------------------------------------
module hptc_ctrl import hptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.req_is_set)
                    begin
                        state_next = ST_SETRD;
                    end
                    else if (sts.req_key_zero)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                cmd.slot_read = 1'b1;
                if (sts.hash_done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.entry_write = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_SETRD:
            begin
                cmd.slot_read = 1'b1;
                state_next    = ST_SETWR;
            end
            ST_SETWR:
            begin
                cmd.slot_write = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/hptc_dp.sv -----
// ----------------------------------------------------------------------------
// hptc_dp: cache datapath
// Request register, key mixer, cache table, slot threshold table, probe
// scan, refill/hit write-back, override count, generation and result
// register. CACHE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module hptc_dp import hptc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int PROBE_COUNT   = DEF_PROBE_COUNT,
    parameter int SLOT_COUNT    = DEF_SLOT_COUNT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req_data,
    input  logic      res_stall,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    output logic      res_valid,
    output res_t      res_data
);

    localparam int IDX_W   = $clog2(CACHE_ENTRIES);
    localparam int PW      = $clog2(PROBE_COUNT + 1);
    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [PW-1:0]      PROBE_LAST  = PW'(PROBE_COUNT - 1);
    localparam logic [PW-1:0]      PROBE_NUM   = PW'(PROBE_COUNT);
    localparam logic [6:0]         SLOT_LIMIT  = 7'(SLOT_COUNT);
    localparam logic [HLOW_W-1:0]  HSLOT_LIMIT = HLOW_W'(SLOT_COUNT);

    // Request register
    req_t req_reg;

    // Hash
    logic [63:0]      hash_q;
    logic             hash_done;
    logic [IDX_W-1:0] start_idx;

    // Cache table
    cache_entry_t     cache_mem [CACHE_ENTRIES];
    cache_entry_t     mem_q_reg;
    cache_entry_t     mem_wdata;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] clr_reg;

    // Slot table
    logic [THR_W-1:0]      slot_val_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_pres_reg;
    logic [THR_W-1:0]      slot_q_reg;
    logic [SLOT_AW-1:0]    slot_raddr;
    logic [SLOT_AW-1:0]    set_idx;
    logic                  set_in_range;
    logic                  set_pres;
    logic [THR_W-1:0]      set_val;
    logic                  cur_pres;
    logic                  unchanged;
    logic                  slot_we;

    // Handle decode
    logic [HLOW_W-1:0]  hlow;
    logic [HLOW_W-1:0]  hslot;
    logic               hvalid;
    logic [SLOT_AW-1:0] hslot_idx;
    logic               new_present;
    logic [THR_W-1:0]   new_thr;
    logic [USES_W-1:0]  new_uses;

    // Override count and generation
    logic [COUNT_W-1:0] override_count_reg;
    logic [31:0]        gen_reg;

    // Probe scan
    logic [PW-1:0]     iss_reg;
    logic [PW-1:0]     ev_reg;
    logic              pend_reg;
    logic              issue;
    logic              eval;
    logic              e_match;
    logic              e_stale;
    logic              e_brk;
    logic              e_take;
    logic [IDX_W-1:0]  rep_idx_reg;
    logic [USES_W-1:0] rep_uses_reg;
    logic              rep_present_reg;
    logic [THR_W-1:0]  rep_thr_reg;
    logic              rep_hit_reg;

    // Result
    logic             rsl_pres_reg;
    logic [THR_W-1:0] rsl_thr_reg;
    logic             rsl_hit_reg;
    logic             res_valid_reg;
    res_t             res_data_reg;
    logic             out_free;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
    end

    // Key mixer and start index (second xor-shift folded into the index)
    hptc_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (cmd.load),
        .step  (cmd.hash_step),
        .key   (req_reg.bot_key),
        .done  (hash_done),
        .hash  (hash_q)
    );

    assign start_idx = hash_q[IDX_W-1:0] ^ hash_q[HASH_SHIFT +: IDX_W];

    // Handle decode: slot is low 15 bits minus one
    assign hlow      = HLOW_W'(req_reg.controller_handle & HANDLE_MASK);
    assign hslot     = hlow - HLOW_W'(1);
    assign hvalid    = (req_reg.controller_handle != '0) &&
                       (req_reg.controller_handle != HANDLE_ALL) &&
                       (hlow != '0) && (hslot < HSLOT_LIMIT);
    assign hslot_idx = hslot[SLOT_AW-1:0];

    // Set decode
    assign set_idx      = req_reg.slot_index[SLOT_AW-1:0];
    assign set_in_range = {1'b0, req_reg.slot_index} < SLOT_LIMIT;
    assign set_pres     = !req_reg.clear_override;
    assign set_val      = req_reg.clear_override ? '0 :
                          (req_reg.new_threshold > THRESH_MAX) ? THRESH_MAX :
                          req_reg.new_threshold;
    assign cur_pres     = slot_pres_reg[set_idx];
    // The stored value of an absent slot is never used, so it is not compared
    assign unchanged    = (cur_pres == set_pres) &&
                          (!cur_pres || (slot_q_reg == set_val));
    assign slot_we      = cmd.slot_write && set_in_range && !unchanged;

    // Slot value table
    assign slot_raddr = (req_reg.operation == OP_SET) ? set_idx : hslot_idx;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_val_mem[set_idx] <= set_val;
        end
        if (cmd.slot_read)
        begin
            slot_q_reg <= slot_val_mem[slot_raddr];
        end
    end

    // Slot present bits, override count, generation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_pres_reg      <= '0;
            override_count_reg <= '0;
            gen_reg            <= GEN_RESET;
        end
        else if (slot_we)
        begin
            slot_pres_reg[set_idx] <= set_pres;
            gen_reg                <= gen_reg + 32'd1;
            if (!cur_pres && set_pres)
            begin
                override_count_reg <= override_count_reg + COUNT_W'(1);
            end
            else if (cur_pres && !set_pres)
            begin
                override_count_reg <= override_count_reg - COUNT_W'(1);
            end
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    // Probe issue and evaluate counters
    assign issue     = cmd.probe && (iss_reg != PROBE_NUM);
    assign eval      = cmd.probe && pend_reg;
    assign mem_re    = issue;
    assign mem_raddr = start_idx + IDX_W'(iss_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg  <= '0;
            ev_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            iss_reg  <= '0;
            ev_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.probe)
        begin
            pend_reg <= issue;
            if (issue)
            begin
                iss_reg <= iss_reg + PW'(1);
            end
            if (pend_reg)
            begin
                ev_reg <= ev_reg + PW'(1);
            end
        end
    end

    // Probe entry classification
    assign e_match = (mem_q_reg.key == req_reg.bot_key) && (mem_q_reg.gen == gen_reg);
    assign e_stale = (mem_q_reg.gen != gen_reg) || (mem_q_reg.key == '0);
    assign e_brk   = e_match || e_stale;
    assign e_take  = e_brk || (ev_reg == '0) || (mem_q_reg.uses < rep_uses_reg);

    // Replacement / hit candidate
    always_ff @(posedge clk)
    begin
        if (eval && e_take)
        begin
            rep_idx_reg     <= start_idx + IDX_W'(ev_reg);
            rep_uses_reg    <= mem_q_reg.uses;
            rep_present_reg <= mem_q_reg.present;
            rep_thr_reg     <= mem_q_reg.thr;
            rep_hit_reg     <= e_match && (mem_q_reg.uses != '0);
        end
    end

    // Refill contents
    assign new_present = hvalid && slot_pres_reg[hslot_idx];
    assign new_thr     = new_present ? slot_q_reg : '0;
    assign new_uses    = hvalid ? USES_VALID : USES_INVALID;

    // Cache write port: clearing pass or write-back
    assign mem_we    = cmd.clear_step || cmd.entry_write;
    assign mem_waddr = cmd.clear_step ? clr_reg : rep_idx_reg;

    always_comb
    begin
        mem_wdata     = '0;
        if (!cmd.clear_step)
        begin
            mem_wdata.key = req_reg.bot_key;
            mem_wdata.gen = gen_reg;
            if (rep_hit_reg)
            begin
                mem_wdata.uses    = rep_uses_reg - USES_W'(1);
                mem_wdata.present = rep_present_reg;
                mem_wdata.thr     = rep_thr_reg;
            end
            else
            begin
                mem_wdata.uses    = new_uses;
                mem_wdata.present = new_present;
                mem_wdata.thr     = new_thr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cache_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= cache_mem[mem_raddr];
        end
    end

    // Result fields of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsl_pres_reg <= 1'b0;
            rsl_thr_reg  <= '0;
            rsl_hit_reg  <= 1'b0;
        end
        else if (cmd.entry_write)
        begin
            if (rep_hit_reg)
            begin
                rsl_pres_reg <= rep_present_reg;
                rsl_thr_reg  <= rep_present_reg ? rep_thr_reg : '0;
                rsl_hit_reg  <= 1'b1;
            end
            else
            begin
                rsl_pres_reg <= new_present;
                rsl_thr_reg  <= new_thr;
                rsl_hit_reg  <= 1'b0;
            end
        end
    end

    // Output register
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_data_reg.threshold_present <= rsl_pres_reg;
            res_data_reg.threshold_milli   <= rsl_thr_reg;
            res_data_reg.cache_hit         <= rsl_hit_reg;
            res_data_reg.override_active   <= (override_count_reg != '0);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Status to the controller
    assign sts.clear_done   = (clr_reg == {IDX_W{1'b1}});
    assign sts.req_is_set   = (req_data.operation == OP_SET);
    assign sts.req_key_zero = (req_data.bot_key == '0);
    assign sts.hash_done    = hash_done;
    assign sts.scan_done    = eval && (e_brk || (ev_reg == PROBE_LAST));
    assign sts.out_free     = out_free;

    // Checks
    a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !slot_we |=> $stable(gen_reg))
        else $error("generation moved without a slot write");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        override_count_reg <= COUNT_W'(SLOT_COUNT))
        else $error("override count exceeds slot count");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("cache written while a probe read is issued");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken result");

endmodule

// ----- hdl/hashed_probe_threshold_cache.sv -----
// ----------------------------------------------------------------------------
// hashed_probe_threshold_cache: slot threshold lookup through a hashed cache
// Requests enter on req_valid/req_stall/req_data; one result per request
// leaves on res_valid/res_stall/res_data.
//
// A request is taken when req_valid is high and req_stall low. req_stall
// is low only while the controller is idle; one request is in work at a
// time. A lookup passes through an accept step, key mixing on the single
// 32x32 multiplier, pipelined cache reads of up to PROBE_COUNT entries (the
// scan stops at the first matching or stale entry), a write-back step and
// the result step. A set or clear passes through a slot table read, a slot
// table write and the result; a zero key goes straight to the result. The
// result sits in an output register: a new request is taken while it waits,
// and a stalled receiver only holds the next request in its result state
// until the register frees. After reset the block clears all CACHE_ENTRIES
// cache entries, one entry a cycle, with req_stall high; slot thresholds
// start absent, the override count at zero and the generation at one.
// CACHE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module hashed_probe_threshold_cache import hptc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int PROBE_COUNT   = DEF_PROBE_COUNT,
    parameter int SLOT_COUNT    = DEF_SLOT_COUNT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Requests are taken only while idle
    assign req_stall = ~cmd.idle;

    hptc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    hptc_dp
    #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .PROBE_COUNT   (PROBE_COUNT),
        .SLOT_COUNT    (SLOT_COUNT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .res_stall (res_stall),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule
